### rtl/core/flha_pkg.sv
// Package for the free-list heap allocator.
// Holds the heap constants, the block header layout, codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package flha_pkg;

  // Heap geometry.
  localparam int HEAP_BYTES   = 4096;
  localparam int HDR_BYTES    = 16;
  localparam int HDR_ALIGN    = 8;
  localparam int MIN_SPLIT    = 8;
  localparam int MEM_DEPTH    = HEAP_BYTES;
  localparam int MEM_AW       = $clog2(MEM_DEPTH);
  localparam int HDR_W        = 27;
  localparam int TAG_W        = 8;

  // Input kinds.
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  // Result status codes.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_ZERO      = 4'd1;
  localparam logic [3:0] ST_ALIGN     = 4'd2;
  localparam logic [3:0] ST_OOM       = 4'd3;
  localparam logic [3:0] ST_NOT_OWNED = 4'd4;
  localparam logic [3:0] ST_BAD_PAD   = 4'd5;
  localparam logic [3:0] ST_HDR_RANGE = 4'd6;
  localparam logic [3:0] ST_BAD_BLOCK = 4'd7;
  localparam logic [3:0] ST_DBL_FREE  = 4'd9;

  // Configuration register indexes.
  localparam logic CFG_HEAP_BYTES = 1'b0;
  localparam logic CFG_FIT_POLICY = 1'b1;

  // One block header as stored in the header memory.
  typedef struct packed {
    logic [12:0]       sz;
    logic              fr;
    logic              hp;
    logic [MEM_AW-1:0] pv;
  } hdr_t;

  // One result beat.
  typedef struct packed {
    logic [3:0]  status;
    logic [11:0] payload;
    logic [12:0] used;
    logic [8:0]  alloc;
    logic [8:0]  free;
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_INIT, S_IDLE,
    S_A_EV, S_A_SPL, S_A_RA, S_A_WB,
    S_F_TAG, S_F_HDR,
    S_M_GO, S_M_X, S_M_N, S_M_A, S_M_END,
    S_C_GO, S_C_EV, S_DONE
  } state_t;

endpackage

### rtl/core/flha_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module flha_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/flha_ctrl.sv
// Sequencer of the heap allocator: walks the block chain in the header memory,
// splits, merges and keeps the counters. Depends on flha_pkg.
`timescale 1ns / 1ps

module flha_ctrl
  import flha_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr_req,
  input  logic [12:0]       heap_bytes,
  input  logic              fit_policy,
  input  logic              start,
  input  logic [1:0]        kind,
  input  logic [12:0]       req_size,
  input  logic [8:0]        align_bytes,
  input  logic [15:0]       addr,
  output logic              busy,
  output logic              res_valid,
  output res_t              res,
  output logic              hdr_we,
  output logic [MEM_AW-1:0] hdr_waddr,
  output logic [HDR_W-1:0]  hdr_wdata,
  output logic [MEM_AW-1:0] hdr_raddr,
  input  logic [HDR_W-1:0]  hdr_rdata,
  output logic              tag_we,
  output logic [MEM_AW-1:0] tag_waddr,
  output logic [TAG_W-1:0]  tag_wdata,
  output logic [MEM_AW-1:0] tag_raddr,
  input  logic [TAG_W-1:0]  tag_rdata
);

  state_t            state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [MEM_AW-1:0] h_r, h_nxt;
  logic [MEM_AW-1:0] best_r, best_nxt;
  logic [MEM_AW-1:0] mb_r, mb_nxt;
  logic [MEM_AW-1:0] a_r, a_nxt;
  logic [MEM_AW-1:0] n_r, n_nxt;
  hdr_t              hold_r, hold_nxt;
  hdr_t              fhdr_r, fhdr_nxt;
  logic              found_r, found_nxt;
  logic              phase_r, phase_nxt;
  logic [13:0]       need_r, need_nxt;
  logic [12:0]       sur_r, sur_nxt;
  logic [12:0]       req_r, req_nxt;
  logic [8:0]        align_r, align_nxt;
  logic [15:0]       addr_r, addr_nxt;
  logic [3:0]        status_r, status_nxt;
  logic [12:0]       pay_r, pay_nxt;
  logic [12:0]       used_r, used_nxt;
  logic [8:0]        alloc_r, alloc_nxt;
  logic [8:0]        free_r, free_nxt;
  logic [8:0]        cnt_r, cnt_nxt;

  // Shared decode of the current header read.
  logic [12:0] cap;
  logic [13:0] cap14;
  logic        usable;
  hdr_t        rd;
  hdr_t        init_hdr;
  logic [13:0] h_nx;
  logic        walk_end;
  logic [7:0]  amask;
  logic [7:0]  p_lo;
  logic [13:0] need;
  logic        fit_ok;
  logic [12:0] sur;
  logic        take;
  logic        a_stop;
  logic [13:0] s_rnd;
  logic [13:0] split_n;
  logic [13:0] split_a;
  logic        split_ok;
  logic [7:0]  pad;
  logic [12:0] pay;
  logic [12:0] pay_m1;
  logic        f_bad_tag;
  logic        f_bad_rng;
  logic [15:0] f_h16;
  logic [12:0] f_p;
  logic        f_bad_blk;
  logic [13:0] m_nx;
  logic        m_go;
  logic        m_skip;
  logic [13:0] m_sum;
  logic [12:0] m_s;
  logic [13:0] m_a;
  logic        q_ok;
  logic        in_bad_align;

  assign cap      = (heap_bytes > 13'(HEAP_BYTES)) ? 13'(HEAP_BYTES) : heap_bytes;
  assign cap14    = {1'b0, cap};
  assign usable   = cap > 13'(HDR_BYTES);
  assign rd       = hdr_t'(hdr_rdata);
  assign init_hdr = '{sz: cap - 13'(HDR_BYTES), fr: 1'b1, hp: 1'b0, pv: '0};
  assign h_nx     = {2'b0, h_r} + 14'(HDR_BYTES) + {1'b0, rd.sz};
  assign walk_end = h_nx >= cap14;

  // Fit test for the block under the walk pointer.
  assign amask  = align_r[7:0] - 8'd1;
  assign p_lo   = h_r[7:0] + 8'(HDR_BYTES);
  assign need   = {5'b0, align_r} - {6'b0, (p_lo & amask)} + {1'b0, req_r};
  assign fit_ok = rd.fr && ({1'b0, rd.sz} >= need);
  assign sur    = 13'({1'b0, rd.sz} - need);
  assign take   = fit_ok && (!found_r || (fit_policy && (sur < sur_r)));
  assign a_stop = (fit_ok && !fit_policy) || walk_end;

  // Split of the chosen block.
  assign s_rnd    = (need_r + 14'(HDR_ALIGN - 1)) & ~14'(HDR_ALIGN - 1);
  assign split_n  = {2'b0, best_r} + 14'(HDR_BYTES) + s_rnd;
  assign split_a  = {2'b0, best_r} + 14'(HDR_BYTES) + {1'b0, hold_r.sz};
  assign split_ok = ({1'b0, hold_r.sz} >= (s_rnd + 14'(HDR_BYTES + MIN_SPLIT)))
                    && (split_n < cap14);
  assign pad      = 8'(need_r - {1'b0, req_r});
  assign pay      = {1'b0, best_r} + 13'(HDR_BYTES) + {5'b0, pad};
  assign pay_m1   = pay - 13'd1;

  // Free checks.
  assign f_bad_tag = (tag_rdata == '0) || ({8'b0, tag_rdata} > addr_r);
  assign f_bad_rng = addr_r < ({8'b0, tag_rdata} + 16'(HDR_BYTES));
  assign f_h16     = addr_r - {8'b0, tag_rdata} - 16'(HDR_BYTES);
  assign f_p       = {1'b0, h_r} + 13'(HDR_BYTES);
  assign f_bad_blk = (rd.sz == '0) || (({1'b0, f_p} + {1'b0, rd.sz}) > cap14);
  assign q_ok      = fhdr_r.hp && ({1'b0, fhdr_r.pv} < cap);

  // Merge of the block at mb_r with its physical successor.
  assign m_nx   = {2'b0, mb_r} + 14'(HDR_BYTES) + {1'b0, rd.sz};
  assign m_go   = (!phase_r || rd.fr) && (m_nx < cap14);
  assign m_skip = !phase_r && !rd.fr;
  assign m_sum  = {1'b0, hold_r.sz} + 14'(HDR_BYTES) + {1'b0, rd.sz};
  assign m_s    = (m_sum > cap14) ? cap : m_sum[12:0];
  assign m_a    = {2'b0, mb_r} + 14'(HDR_BYTES) + {1'b0, m_s};

  assign in_bad_align = (align_bytes == '0) || align_bytes[8]
                        || ((align_bytes & (align_bytes - 9'd1)) != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (&clr_cnt_r) state_nxt = S_INIT;
      end
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_nxt = S_C_GO;
          if (kind == KIND_ALLOC && req_size != '0 && usable && !in_bad_align) begin
            state_nxt = S_A_EV;
          end else if (kind == KIND_FREE && usable && addr != '0
                       && addr < {3'b0, cap}) begin
            state_nxt = S_F_TAG;
          end
        end
      end
      S_A_EV: begin
        if (a_stop) state_nxt = S_A_SPL;
      end
      S_A_SPL: begin
        if (!found_r) begin
          state_nxt = S_C_GO;
        end else if (split_ok && split_a < cap14) begin
          state_nxt = S_A_RA;
        end else begin
          state_nxt = S_A_WB;
        end
      end
      S_A_RA: state_nxt = S_A_WB;
      S_A_WB: state_nxt = S_C_GO;
      S_F_TAG: begin
        state_nxt = (f_bad_tag || f_bad_rng) ? S_C_GO : S_F_HDR;
      end
      S_F_HDR: begin
        state_nxt = (f_bad_blk || rd.fr) ? S_C_GO : S_M_GO;
      end
      S_M_GO: state_nxt = S_M_X;
      S_M_X: state_nxt = m_go ? S_M_N : S_M_END;
      S_M_N: begin
        if (m_skip || m_a >= cap14) state_nxt = S_M_END;
        else state_nxt = S_M_A;
      end
      S_M_A: state_nxt = S_M_END;
      S_M_END: begin
        state_nxt = (!phase_r && q_ok) ? S_M_GO : S_C_GO;
      end
      S_C_GO: state_nxt = usable ? S_C_EV : S_DONE;
      S_C_EV: begin
        if (walk_end) state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (clr_req) state_nxt = S_CLEAR;
  end

  // Datapath, memory ports and counters.
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    h_nxt       = h_r;
    best_nxt    = best_r;
    mb_nxt      = mb_r;
    a_nxt       = a_r;
    n_nxt       = n_r;
    hold_nxt    = hold_r;
    fhdr_nxt    = fhdr_r;
    found_nxt   = found_r;
    phase_nxt   = phase_r;
    need_nxt    = need_r;
    sur_nxt     = sur_r;
    req_nxt     = req_r;
    align_nxt   = align_r;
    addr_nxt    = addr_r;
    status_nxt  = status_r;
    pay_nxt     = pay_r;
    used_nxt    = used_r;
    alloc_nxt   = alloc_r;
    free_nxt    = free_r;
    cnt_nxt     = cnt_r;
    hdr_we      = 1'b0;
    hdr_waddr   = '0;
    hdr_wdata   = '0;
    hdr_raddr   = '0;
    tag_we      = 1'b0;
    tag_waddr   = '0;
    tag_wdata   = '0;
    tag_raddr   = '0;
    case (state_r)
      // Zero both memories, one entry a cycle.
      S_CLEAR: begin
        hdr_we      = 1'b1;
        hdr_waddr   = clr_cnt_r;
        tag_we      = 1'b1;
        tag_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      S_INIT: begin
        if (usable) begin
          hdr_we    = 1'b1;
          hdr_wdata = init_hdr;
        end
        used_nxt  = '0;
        alloc_nxt = '0;
        free_nxt  = {8'b0, usable};
      end
      // Take the command beat, do the checks that need no memory and rebuild the heap on a reset command.
      S_IDLE: begin
        if (start) begin
          req_nxt    = req_size;
          align_nxt  = align_bytes;
          addr_nxt   = addr;
          status_nxt = ST_OK;
          pay_nxt    = '0;
          h_nxt      = '0;
          found_nxt  = 1'b0;
          tag_raddr  = MEM_AW'(addr - 16'd1);
          case (kind)
            KIND_ALLOC: begin
              if (req_size == '0 || !usable) status_nxt = ST_ZERO;
              else if (in_bad_align) status_nxt = ST_ALIGN;
            end
            KIND_FREE: begin
              if (!usable) status_nxt = ST_ZERO;
              else if (addr == '0 || addr >= {3'b0, cap}) status_nxt = ST_NOT_OWNED;
            end
            KIND_RESET: begin
              if (usable) begin
                hdr_we    = 1'b1;
                hdr_wdata = init_hdr;
                used_nxt  = '0;
                alloc_nxt = '0;
              end else begin
                status_nxt = ST_ZERO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Allocation walk: one header per cycle.
      S_A_EV: begin
        if (take) begin
          found_nxt = 1'b1;
          best_nxt  = h_r;
          hold_nxt  = rd;
          need_nxt  = need;
          sur_nxt   = sur;
        end
        h_nxt     = h_nx[MEM_AW-1:0];
        hdr_raddr = h_nx[MEM_AW-1:0];
      end
      // Report OOM if nothing fits; else carve the remainder into a new free block when it is large enough.
      S_A_SPL: begin
        if (!found_r) begin
          status_nxt = ST_OOM;
        end else if (split_ok) begin
          hdr_we      = 1'b1;
          hdr_waddr   = split_n[MEM_AW-1:0];
          hdr_wdata   = hdr_t'{sz: 13'({1'b0, hold_r.sz} - s_rnd - 14'(HDR_BYTES)),
                               fr: 1'b1, hp: 1'b1, pv: best_r};
          n_nxt       = split_n[MEM_AW-1:0];
          a_nxt       = split_a[MEM_AW-1:0];
          hdr_raddr   = split_a[MEM_AW-1:0];
          hold_nxt.sz = s_rnd[12:0];
        end
      end
      S_A_RA: begin
        hdr_we    = 1'b1;
        hdr_waddr = a_r;
        hdr_wdata = hdr_t'{sz: rd.sz, fr: rd.fr, hp: 1'b1, pv: n_r};
      end
      // Mark the block used, record the padding and update the counters.
      S_A_WB: begin
        hdr_we    = 1'b1;
        hdr_waddr = best_r;
        hdr_wdata = hdr_t'{sz: hold_r.sz, fr: 1'b0, hp: hold_r.hp, pv: hold_r.pv};
        used_nxt  = used_r + 13'(HDR_BYTES) + hold_r.sz;
        alloc_nxt = alloc_r + 9'd1;
        pay_nxt   = pay;
        if (pay_m1 < cap) begin
          tag_we    = 1'b1;
          tag_waddr = pay_m1[MEM_AW-1:0];
          tag_wdata = pad;
        end
      end
      // Rebuild the header position from the padding tag.
      S_F_TAG: begin
        if (f_bad_tag) begin
          status_nxt = ST_BAD_PAD;
        end else if (f_bad_rng) begin
          status_nxt = ST_HDR_RANGE;
        end else begin
          h_nxt     = f_h16[MEM_AW-1:0];
          hdr_raddr = f_h16[MEM_AW-1:0];
        end
      end
      S_F_HDR: begin
        if (f_bad_blk) begin
          status_nxt = ST_BAD_BLOCK;
        end else if (rd.fr) begin
          status_nxt = ST_DBL_FREE;
        end else begin
          used_nxt  = used_r - 13'(HDR_BYTES) - rd.sz;
          alloc_nxt = alloc_r - 9'd1;
          hdr_we    = 1'b1;
          hdr_waddr = h_r;
          hdr_wdata = hdr_t'{sz: rd.sz, fr: 1'b1, hp: rd.hp, pv: rd.pv};
          fhdr_nxt  = rd;
          mb_nxt    = h_r;
          phase_nxt = 1'b0;
        end
      end
      // Merge: read the base block, then its successor, then fix the back link.
      S_M_GO: begin
        hdr_raddr = mb_r;
      end
      S_M_X: begin
        hold_nxt  = rd;
        hdr_raddr = m_nx[MEM_AW-1:0];
      end
      S_M_N: begin
        if (!m_skip) begin
          hdr_we    = 1'b1;
          hdr_waddr = mb_r;
          hdr_wdata = hdr_t'{sz: m_s, fr: hold_r.fr, hp: hold_r.hp, pv: hold_r.pv};
          a_nxt     = m_a[MEM_AW-1:0];
          hdr_raddr = m_a[MEM_AW-1:0];
        end
      end
      S_M_A: begin
        hdr_we    = 1'b1;
        hdr_waddr = a_r;
        hdr_wdata = hdr_t'{sz: rd.sz, fr: rd.fr, hp: 1'b1, pv: mb_r};
      end
      S_M_END: begin
        if (!phase_r && q_ok) begin
          mb_nxt    = fhdr_r.pv;
          phase_nxt = 1'b1;
        end
      end
      // Free block count: walk the whole chain.
      S_C_GO: begin
        h_nxt     = '0;
        cnt_nxt   = '0;
        hdr_raddr = '0;
        if (!usable) free_nxt = '0;
      end
      S_C_EV: begin
        cnt_nxt   = cnt_r + {8'b0, rd.fr};
        free_nxt  = cnt_r + {8'b0, rd.fr};
        h_nxt     = h_nx[MEM_AW-1:0];
        hdr_raddr = h_nx[MEM_AW-1:0];
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
    if (clr_req) clr_cnt_nxt = '0;
  end

  assign busy          = state_r != S_IDLE;
  assign res_valid     = state_r == S_DONE;
  assign res.status    = status_r;
  assign res.payload   = pay_r[11:0];
  assign res.used      = used_r;
  assign res.alloc     = alloc_r;
  assign res.free      = free_r;

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      used_r    <= '0;
      alloc_r   <= '0;
      free_r    <= '0;
      found_r   <= 1'b0;
      phase_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      used_r    <= used_nxt;
      alloc_r   <= alloc_nxt;
      free_r    <= free_nxt;
      found_r   <= found_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    h_r      <= h_nxt;
    best_r   <= best_nxt;
    mb_r     <= mb_nxt;
    a_r      <= a_nxt;
    n_r      <= n_nxt;
    hold_r   <= hold_nxt;
    fhdr_r   <= fhdr_nxt;
    need_r   <= need_nxt;
    sur_r    <= sur_nxt;
    req_r    <= req_nxt;
    align_r  <= align_nxt;
    addr_r   <= addr_nxt;
    status_r <= status_nxt;
    pay_r    <= pay_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

### rtl/core/free_list_heap_allocator.sv
// Top level of the free-list heap allocator: configuration registers, result
// register and the header and tag memories. Depends on flha_pkg, flha_ram, flha_ctrl.
//
//   Channel   Handshake             Beat contents
//   in_       start / busy          kind, req_size, align_bytes, addr
//   out_      out_valid (1 cycle)   status, payload_addr, used_bytes, counters
//   cfg_      cfg_we                cfg_index, cfg_wdata
//
// An allocate walks the chain block by block, then splits the chosen block when the
// remainder is large enough, relinks the following block when the split needs it and
// marks the chosen block used; then a walk of the whole chain counts the free blocks.
// A free checks the padding tag and the header and does both merges before the same
// count. The result beat is registered after the S_DONE state and shows for one cycle.
// After reset and after each heap_bytes write, a clearing pass zeroes both memories
// while busy is high.
`timescale 1ns / 1ps

module free_list_heap_allocator
  import flha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [12:0] in_req_size,
  input  logic [8:0]  in_align_bytes,
  input  logic [15:0] in_addr,
  output logic        out_valid,
  output logic [3:0]  out_status,
  output logic [11:0] out_payload_addr,
  output logic [12:0] out_used_bytes,
  output logic [8:0]  out_live_allocations,
  output logic [8:0]  out_free_blocks,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_wdata
);

  logic [12:0]       heap_bytes_r;
  logic              fit_policy_r;
  logic              clr_req;
  logic              res_valid;
  res_t              res;
  res_t              res_r;
  logic              out_valid_r;
  logic              hdr_we;
  logic [MEM_AW-1:0] hdr_waddr;
  logic [HDR_W-1:0]  hdr_wdata;
  logic [MEM_AW-1:0] hdr_raddr;
  logic [HDR_W-1:0]  hdr_rdata;
  logic              tag_we;
  logic [MEM_AW-1:0] tag_waddr;
  logic [TAG_W-1:0]  tag_wdata;
  logic [MEM_AW-1:0] tag_raddr;
  logic [TAG_W-1:0]  tag_rdata;

  // A heap size write rebuilds the heap.
  assign clr_req = cfg_we && (cfg_index == CFG_HEAP_BYTES);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= 13'(HEAP_BYTES);
      fit_policy_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HEAP_BYTES) heap_bytes_r <= cfg_wdata;
      else fit_policy_r <= cfg_wdata[0];
    end
  end

  // Result register: one beat per finished command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
    if (res_valid) res_r <= res;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = res_r.status;
  assign out_payload_addr     = res_r.payload;
  assign out_used_bytes       = res_r.used;
  assign out_live_allocations = res_r.alloc;
  assign out_free_blocks      = res_r.free;

  flha_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr_req     (clr_req),
    .heap_bytes  (heap_bytes_r),
    .fit_policy  (fit_policy_r),
    .start       (start),
    .kind        (in_kind),
    .req_size    (in_req_size),
    .align_bytes (in_align_bytes),
    .addr        (in_addr),
    .busy        (busy),
    .res_valid   (res_valid),
    .res         (res),
    .hdr_we      (hdr_we),
    .hdr_waddr   (hdr_waddr),
    .hdr_wdata   (hdr_wdata),
    .hdr_raddr   (hdr_raddr),
    .hdr_rdata   (hdr_rdata),
    .tag_we      (tag_we),
    .tag_waddr   (tag_waddr),
    .tag_wdata   (tag_wdata),
    .tag_raddr   (tag_raddr),
    .tag_rdata   (tag_rdata)
  );

  // Block headers, indexed by byte offset.
  flha_ram #(.W(HDR_W), .D(MEM_DEPTH)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wdata),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  // Padding tags, stored just below each payload.
  flha_ram #(.W(TAG_W), .D(MEM_DEPTH)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

endmodule
